>>> hdl/pi_speed_regulator_antiwindup_unit_macros.svh
`ifndef PI_SPEED_REGULATOR_ANTIWINDUP_UNIT_MACROS_SVH
`define PI_SPEED_REGULATOR_ANTIWINDUP_UNIT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define PISR_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define PISR_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> hdl/pisreg_pkg.sv
`timescale 1ns / 1ps

package pisreg_pkg;

   localparam int MUL_W = 24;
   localparam int CNT_W = 5;
   localparam int DECAY_SHIFT = 16;
   localparam logic [MUL_W-1:0] DECAY_LIMITED = 24'd58982;
   localparam logic [MUL_W-1:0] DECAY_SMALL = 24'd62259;

   localparam logic [23:0] KP_RESET = 24'd65536;
   localparam logic [23:0] KI_RESET = 24'd655;
   localparam logic [30:0] OUT_LIMIT_RESET = 31'd6553600;
   localparam logic [30:0] IN_LIMIT_RESET = 31'd6553600;

   typedef enum logic [1:0] {
      CSR_KP,
      CSR_KI,
      CSR_OUT_LIMIT,
      CSR_IN_LIMIT
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL_KP,
      ST_DRIVE,
      ST_MUL_KI,
      ST_ADD_KI,
      ST_MUL_DECAY,
      ST_CLAMP,
      ST_DONE
   } state_type;

endpackage

>>> hdl/pi_speed_regulator_antiwindup_unit.sv
`timescale 1ns / 1ps
// PI speed regulator with anti-windup, signed fixed point with FRAC_BITS fraction bits.
// The request channel carries one transaction per item: req_tuser set means a new speed
// goal, clear means a speed measurement; req_tdata holds the value. A goal transaction is
// clamped to the input limit, stored, and produces no response. A measurement produces one
// response transaction carrying the saturated drive. All products go through one shift-add
// multiplier that consumes one multiplier bit per cycle. A measurement needs two products,
// or three when the error is small and the drive did not saturate. The block is ready for
// the next request in the cycle in which the response becomes valid. The response sits in
// an output register, so a request can be accepted while an earlier response is still
// waiting; if the receiver stalls, a finished measurement waits in its last step until the
// output register is free. Configuration writes on the csr port are taken at once; writing
// a gain clears the integral. Synchronous reset restores the register defaults, clears the
// goal and the integral, and drops any pending response.

module pi_speed_regulator_antiwindup_unit
   import pisreg_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // drive
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [30:0] csr_wdata
);

   `include "pi_speed_regulator_antiwindup_unit_macros.svh"

   localparam int OP_W = (59 - FRAC_BITS > 33) ? 59 - FRAC_BITS : 33;
   localparam int PROD_W = OP_W + MUL_W;
   localparam logic [32:0] SMALL_ERROR = 33'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

   state_type state_ff, state_in;
   logic [23:0] kp_ff, kp_in;
   logic [23:0] ki_ff, ki_in;
   logic [30:0] out_limit_ff, out_limit_in;
   logic [30:0] in_limit_ff, in_limit_in;
   logic signed [31:0] goal_ff, goal_in;
   logic signed [31:0] integ_ff, integ_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic cmd_ff, cmd_in;
   logic signed [31:0] value_ff, value_in;
   logic [OP_W-1:0] mcand_ff, mcand_in;
   logic [MUL_W-1:0] mplier_ff, mplier_in;
   logic [OP_W-1:0] acc_ff, acc_in;
   logic [MUL_W-1:0] low_ff, low_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic err_neg_ff, err_neg_in;
   logic op_neg_ff, op_neg_in;
   logic small_ff, small_in;
   logic dec_ff, dec_in;
   logic [32:0] err_mag_ff, err_mag_in;
   logic signed [OP_W:0] wide_ff, wide_in;
   logic [31:0] drive_ff, drive_in;

   logic [OP_W:0] step_sum;
   logic [PROD_W-1:0] prod;
   logic [OP_W-1:0] prod_f;
   logic [OP_W-1:0] prod_d;
   logic signed [OP_W:0] prod_f_s;
   logic signed [OP_W:0] prod_d_s;
   logic signed [32:0] err_w;
   logic signed [32:0] integ_w;
   logic signed [31:0] in_lim_s;
   logic signed [OP_W+1:0] drive_w;
   logic signed [OP_W+1:0] out_lim_d;
   logic signed [OP_W:0] out_lim_c;
   logic signed [OP_W:0] ki_sum;
   logic signed [OP_W:0] ki_sum_mag;
   logic signed [OP_W:0] clamp_src;
   logic slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      step_sum = {1'b0, acc_ff} + (mplier_ff[0] ? {1'b0, mcand_ff} : {(OP_W + 1){1'b0}});
      prod = {acc_ff, low_ff};
      prod_f = OP_W'(prod >> FRAC_BITS);
      prod_d = OP_W'(prod >> DECAY_SHIFT);
      prod_f_s = err_neg_ff ? -$signed({1'b0, prod_f}) : $signed({1'b0, prod_f});
      prod_d_s = op_neg_ff ? -$signed({1'b0, prod_d}) : $signed({1'b0, prod_d});
      err_w = $signed({goal_ff[31], goal_ff}) - $signed({value_ff[31], value_ff});
      integ_w = $signed({integ_ff[31], integ_ff});
      in_lim_s = $signed({1'b0, in_limit_ff});
      drive_w = $signed({prod_f_s[OP_W], prod_f_s})
         + $signed({{(OP_W - 30){integ_ff[31]}}, integ_ff});
      out_lim_d = $signed({{(OP_W - 29){1'b0}}, out_limit_ff});
      out_lim_c = $signed({{(OP_W - 30){1'b0}}, out_limit_ff});
      ki_sum = prod_f_s + $signed({{(OP_W - 31){integ_ff[31]}}, integ_ff});
      ki_sum_mag = ki_sum[OP_W] ? -ki_sum : ki_sum;
      clamp_src = dec_ff ? prod_d_s : wide_ff;
   end

   always_comb begin
      state_in = state_ff;
      kp_in = kp_ff;
      ki_in = ki_ff;
      out_limit_in = out_limit_ff;
      in_limit_in = in_limit_ff;
      goal_in = goal_ff;
      integ_in = integ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      cmd_in = cmd_ff;
      value_in = value_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      acc_in = acc_ff;
      low_in = low_ff;
      cnt_in = cnt_ff;
      err_neg_in = err_neg_ff;
      op_neg_in = op_neg_ff;
      small_in = small_ff;
      dec_in = dec_ff;
      err_mag_in = err_mag_ff;
      wide_in = wide_ff;
      drive_in = drive_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tuser;
               value_in = $signed(req_tdata);
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (cmd_ff) begin
               if (value_ff > in_lim_s) begin
                  goal_in = in_lim_s;
               end else if (value_ff < -in_lim_s) begin
                  goal_in = -in_lim_s;
               end else begin
                  goal_in = value_ff;
               end
               if (goal_in == 32'sd0) begin
                  integ_in = 32'sd0;
               end
               state_in = ST_IDLE;
            end else begin
               err_neg_in = err_w[32];
               err_mag_in = err_w[32] ? 33'(-err_w) : 33'(err_w);
               small_in = (err_mag_in < SMALL_ERROR);
               mcand_in = OP_W'(err_mag_in);
               mplier_in = MUL_W'(kp_ff);
               acc_in = '0;
               cnt_in = '0;
               state_in = ST_MUL_KP;
            end
         end
         ST_MUL_KP, ST_MUL_KI, ST_MUL_DECAY: begin
            acc_in = step_sum[OP_W:1];
            low_in = {step_sum[0], low_ff[MUL_W-1:1]};
            mplier_in = mplier_ff >> 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MUL_W - 1)) begin
               case (state_ff)
                  ST_MUL_KP: state_in = ST_DRIVE;
                  ST_MUL_KI: state_in = ST_ADD_KI;
                  default: state_in = ST_CLAMP;
               endcase
            end
         end
         ST_DRIVE: begin
            acc_in = '0;
            cnt_in = '0;
            if (drive_w > out_lim_d || drive_w < -out_lim_d) begin
               drive_in = (drive_w > out_lim_d) ? 32'(out_lim_d) : 32'(-out_lim_d);
               op_neg_in = integ_ff[31];
               mcand_in = OP_W'(integ_ff[31] ? 33'(-integ_w) : 33'(integ_w));
               mplier_in = DECAY_LIMITED;
               dec_in = 1'b1;
               state_in = ST_MUL_DECAY;
            end else begin
               drive_in = 32'(drive_w);
               mcand_in = OP_W'(err_mag_ff);
               mplier_in = MUL_W'(ki_ff);
               state_in = ST_MUL_KI;
            end
         end
         ST_ADD_KI: begin
            wide_in = ki_sum;
            acc_in = '0;
            cnt_in = '0;
            if (small_ff) begin
               op_neg_in = ki_sum[OP_W];
               mcand_in = OP_W'(ki_sum_mag);
               mplier_in = DECAY_SMALL;
               dec_in = 1'b1;
               state_in = ST_MUL_DECAY;
            end else begin
               dec_in = 1'b0;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (clamp_src > out_lim_c) begin
               integ_in = 32'(out_lim_c);
            end else if (clamp_src < -out_lim_c) begin
               integ_in = 32'(-out_lim_c);
            end else begin
               integ_in = 32'(clamp_src);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = drive_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         case (csr_addr)
            CSR_KP: begin
               kp_in = csr_wdata[23:0];
               integ_in = 32'sd0;
            end
            CSR_KI: begin
               ki_in = csr_wdata[23:0];
               integ_in = 32'sd0;
            end
            CSR_OUT_LIMIT: out_limit_in = csr_wdata;
            CSR_IN_LIMIT: in_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kp_ff <= KP_RESET;
         ki_ff <= KI_RESET;
         out_limit_ff <= OUT_LIMIT_RESET;
         in_limit_ff <= IN_LIMIT_RESET;
         goal_ff <= 32'sd0;
         integ_ff <= 32'sd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kp_ff <= kp_in;
         ki_ff <= ki_in;
         out_limit_ff <= out_limit_in;
         in_limit_ff <= in_limit_in;
         goal_ff <= goal_in;
         integ_ff <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cmd_ff <= cmd_in;
      value_ff <= value_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff <= acc_in;
      low_ff <= low_in;
      cnt_ff <= cnt_in;
      err_neg_ff <= err_neg_in;
      op_neg_ff <= op_neg_in;
      small_ff <= small_in;
      dec_ff <= dec_in;
      err_mag_ff <= err_mag_in;
      wide_ff <= wide_in;
      drive_ff <= drive_in;
   end

   `PISR_ASSERT_NEXT(a_done_loads_rsp, state_ff == ST_DONE && slot_free,
      rsp_valid_ff && rsp_data_ff == $past(drive_ff) && state_ff == ST_IDLE,
      "finished measurement did not reach the response register")
   `PISR_ASSERT(a_mul_count, !(state_ff == ST_MUL_KP || state_ff == ST_MUL_KI
      || state_ff == ST_MUL_DECAY) || cnt_ff < CNT_W'(MUL_W),
      "multiplier step count ran past the multiplier width")
   `PISR_ASSERT_NEXT(a_integ_clamped, state_ff == ST_CLAMP,
      integ_ff <= $signed({1'b0, out_limit_ff}) && integ_ff >= -$signed({1'b0, out_limit_ff}),
      "integral left outside the output limit")
   `PISR_ASSERT_NEXT(a_goal_clamped, state_ff == ST_LOAD && cmd_ff,
      goal_ff <= $signed({1'b0, in_limit_ff}) && goal_ff >= -$signed({1'b0, in_limit_ff}),
      "speed goal stored outside the input limit")

endmodule
